@@ rtl/dft_pkg.sv @@
package dft_pkg;

   localparam int COLUMN_WIDTH     = 16;
   localparam int ROW_WIDTH        = 32;
   localparam int BYTE_COUNT_WIDTH = 48;

   localparam int COLUMN_OUT_WIDTH = 16;
   localparam int ROW_OUT_WIDTH    = 32;
   localparam int BYTES_OUT_WIDTH  = 48;
   localparam int SKIP_WIDTH       = 32;
   localparam int LIMIT_ROW_WIDTH  = 32;
   localparam int LIMIT_BYTE_WIDTH = 48;
   localparam int CMP_WIDTH        = 64;

   localparam int CSR_INDEX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH   = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELIMITER  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_ROWS  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_LIMIT  = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_LIMIT = 8'd3;

   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] CH_NL           = 8'h0A;
   localparam logic [7:0] CH_QUOTE        = 8'h22;
   localparam logic [7:0] CH_SPACE        = 8'h20;
   localparam logic [7:0] CH_TAB          = 8'h09;

   typedef enum logic {
      MODE_BYTE = 1'b0,
      MODE_END  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      KIND_FIELD_BYTE = 3'd0,
      KIND_FIELD_END  = 3'd1,
      KIND_ROW_END    = 3'd2,
      KIND_ERROR      = 3'd3,
      KIND_SUMMARY    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_QUOTES = 2'd1,
      STATUS_MID_ROW    = 2'd2,
      STATUS_SHORT      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_SKIP  = 2'd0,
      PHASE_PARSE = 2'd1,
      PHASE_STOP  = 2'd2,
      PHASE_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      QUOTE_OUTSIDE = 2'd0,
      QUOTE_CLOSED  = 2'd1,
      QUOTE_INSIDE  = 2'd2
   } quote_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type                     kind;
      logic [7:0]                   field_byte;
      logic [COLUMN_OUT_WIDTH-1:0]  column_index;
      logic [ROW_OUT_WIDTH-1:0]     row_index;
      status_type                   status;
      logic [BYTES_OUT_WIDTH-1:0]   bytes_consumed;
      logic [SKIP_WIDTH-1:0]        rows_skipped;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]                  delimiter;
      logic [SKIP_WIDTH-1:0]       skip_rows;
      logic [LIMIT_ROW_WIDTH-1:0]  row_limit;
      logic [LIMIT_BYTE_WIDTH-1:0] byte_limit;
      logic                        skip_load;
      logic [SKIP_WIDTH-1:0]       skip_value;
   } cfg_bus_type;

endpackage

@@ rtl/dft_csr_regs.sv @@
module dft_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dft_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dft_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                skip_open,
   output dft_pkg::cfg_bus_type                cfg
);

   logic [7:0]                           delimiter_ff, delimiter_in;
   logic [dft_pkg::SKIP_WIDTH-1:0]       skip_rows_ff, skip_rows_in;
   logic [dft_pkg::LIMIT_ROW_WIDTH-1:0]  row_limit_ff, row_limit_in;
   logic [dft_pkg::LIMIT_BYTE_WIDTH-1:0] byte_limit_ff, byte_limit_in;
   logic                                 write;
   logic                                 skip_load;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      delimiter_in  = delimiter_ff;
      skip_rows_in  = skip_rows_ff;
      row_limit_in  = row_limit_ff;
      byte_limit_in = byte_limit_ff;
      skip_load     = 1'b0;
      if (write) begin
         unique case (csr_index)
            dft_pkg::CSR_DELIMITER: delimiter_in = csr_wdata[7:0];
            dft_pkg::CSR_SKIP_ROWS: begin
               // only before any byte has been examined
               if (skip_open) begin
                  skip_rows_in = csr_wdata[dft_pkg::SKIP_WIDTH-1:0];
                  skip_load    = 1'b1;
               end
            end
            dft_pkg::CSR_ROW_LIMIT:  row_limit_in  = csr_wdata[dft_pkg::LIMIT_ROW_WIDTH-1:0];
            dft_pkg::CSR_BYTE_LIMIT: byte_limit_in = csr_wdata[dft_pkg::LIMIT_BYTE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff  <= dft_pkg::DELIMITER_RESET;
         skip_rows_ff  <= '0;
         row_limit_ff  <= '0;
         byte_limit_ff <= '0;
      end else begin
         delimiter_ff  <= delimiter_in;
         skip_rows_ff  <= skip_rows_in;
         row_limit_ff  <= row_limit_in;
         byte_limit_ff <= byte_limit_in;
      end
   end

   always_comb begin
      cfg.delimiter  = delimiter_ff;
      cfg.skip_rows  = skip_rows_ff;
      cfg.row_limit  = row_limit_ff;
      cfg.byte_limit = byte_limit_ff;
      cfg.skip_load  = skip_load;
      cfg.skip_value = csr_wdata[dft_pkg::SKIP_WIDTH-1:0];
   end

endmodule

@@ rtl/dft_parser.sv @@
module dft_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  dft_pkg::cfg_bus_type     cfg,
   input  logic                     fire,
   input  dft_pkg::req_payload_type item,
   output logic                     res_valid,
   output dft_pkg::rsp_payload_type res,
   output logic                     skip_open
);

   dft_pkg::phase_type                   phase_ff, phase_in;
   dft_pkg::quote_type                   quote_ff, quote_in;
   dft_pkg::status_type                  stop_status_ff, stop_status_in;
   logic                                 nonempty_ff, nonempty_in;
   logic [dft_pkg::COLUMN_WIDTH-1:0]     column_ff, column_in;
   logic [dft_pkg::ROW_WIDTH-1:0]        row_ff, row_in;
   logic [dft_pkg::BYTE_COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [dft_pkg::SKIP_WIDTH-1:0]       skip_rem_ff, skip_rem_in;

   logic [dft_pkg::BYTE_COUNT_WIDTH-1:0] byte_count_inc;
   logic [dft_pkg::COLUMN_WIDTH-1:0]     column_inc;
   logic [dft_pkg::ROW_WIDTH-1:0]        row_inc;
   logic [7:0]                           b;
   logic                                 byte_limit_hit;
   logic                                 row_limit_hit;
   logic                                 row_short;
   logic                                 is_delim;
   logic                                 is_blank;
   dft_pkg::status_type                  summary_status;

   assign b          = item.data_byte;
   assign skip_open  = (phase_ff == dft_pkg::PHASE_SKIP) && (byte_count_ff == '0);

   assign byte_count_inc = (byte_count_ff == '1) ? byte_count_ff : byte_count_ff + 1'b1;
   assign column_inc     = (column_ff == '1) ? column_ff : column_ff + 1'b1;
   assign row_inc        = (row_ff == '1) ? row_ff : row_ff + 1'b1;

   assign byte_limit_hit = (cfg.byte_limit != '0) &&
      (dft_pkg::CMP_WIDTH'(byte_count_ff) >= dft_pkg::CMP_WIDTH'(cfg.byte_limit));
   assign row_short      = dft_pkg::CMP_WIDTH'(row_ff) < dft_pkg::CMP_WIDTH'(cfg.row_limit);
   assign row_limit_hit  = (cfg.row_limit != '0) && !row_short;
   assign is_delim       = (b == cfg.delimiter);
   assign is_blank       = (b == dft_pkg::CH_SPACE) || (b == dft_pkg::CH_TAB);

   always_comb begin
      if (stop_status_ff != dft_pkg::STATUS_OK) begin
         summary_status = stop_status_ff;
      end else if (column_ff != '0) begin
         summary_status = dft_pkg::STATUS_MID_ROW;
      end else if ((cfg.row_limit != '0) && row_short) begin
         summary_status = dft_pkg::STATUS_SHORT;
      end else begin
         summary_status = dft_pkg::STATUS_OK;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      quote_in       = quote_ff;
      stop_status_in = stop_status_ff;
      nonempty_in    = nonempty_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      byte_count_in  = byte_count_ff;
      skip_rem_in    = skip_rem_ff;

      res_valid          = 1'b0;
      res.kind           = dft_pkg::KIND_FIELD_BYTE;
      res.field_byte     = '0;
      res.column_index   = dft_pkg::COLUMN_OUT_WIDTH'(column_ff);
      res.row_index      = dft_pkg::ROW_OUT_WIDTH'(row_ff);
      res.status         = dft_pkg::STATUS_OK;
      res.bytes_consumed = '0;
      res.rows_skipped   = '0;

      if (fire && phase_ff != dft_pkg::PHASE_DONE) begin
         if (item.mode == dft_pkg::MODE_END) begin
            phase_in           = dft_pkg::PHASE_DONE;
            res_valid          = 1'b1;
            res.kind           = dft_pkg::KIND_SUMMARY;
            res.status         = summary_status;
            res.bytes_consumed = dft_pkg::BYTES_OUT_WIDTH'(byte_count_ff);
            res.rows_skipped   = cfg.skip_rows - skip_rem_ff;
         end else if (phase_ff == dft_pkg::PHASE_STOP) begin
            phase_in = dft_pkg::PHASE_STOP;
         end else if (byte_limit_hit) begin
            phase_in = dft_pkg::PHASE_STOP;
         end else if (phase_ff == dft_pkg::PHASE_SKIP && skip_rem_ff != '0) begin
            byte_count_in = byte_count_inc;
            if (b == dft_pkg::CH_NL) begin
               skip_rem_in = skip_rem_ff - 1'b1;
               if (skip_rem_ff == dft_pkg::SKIP_WIDTH'(1)) begin
                  phase_in = dft_pkg::PHASE_PARSE;
               end
            end
         end else if (row_limit_hit) begin
            phase_in = dft_pkg::PHASE_STOP;
         end else begin
            phase_in = dft_pkg::PHASE_PARSE;
            if (is_delim && quote_ff != dft_pkg::QUOTE_INSIDE) begin
               res_valid     = 1'b1;
               res.kind      = dft_pkg::KIND_FIELD_END;
               byte_count_in = byte_count_inc;
               quote_in      = dft_pkg::QUOTE_OUTSIDE;
               nonempty_in   = 1'b0;
               column_in     = column_inc;
            end else if (is_delim) begin
               byte_count_in  = byte_count_inc;
               res_valid      = 1'b1;
               res.field_byte = b;
               nonempty_in    = 1'b1;
            end else if (b == dft_pkg::CH_NL) begin
               if (quote_ff == dft_pkg::QUOTE_INSIDE) begin
                  phase_in           = dft_pkg::PHASE_STOP;
                  stop_status_in     = dft_pkg::STATUS_BAD_QUOTES;
                  res_valid          = 1'b1;
                  res.kind           = dft_pkg::KIND_ERROR;
                  res.status         = dft_pkg::STATUS_BAD_QUOTES;
                  res.bytes_consumed = dft_pkg::BYTES_OUT_WIDTH'(byte_count_ff);
               end else begin
                  res_valid     = 1'b1;
                  res.kind      = dft_pkg::KIND_ROW_END;
                  byte_count_in = byte_count_inc;
                  quote_in      = dft_pkg::QUOTE_OUTSIDE;
                  nonempty_in   = 1'b0;
                  column_in     = '0;
                  row_in        = row_inc;
               end
            end else if (b == dft_pkg::CH_QUOTE) begin
               byte_count_in = byte_count_inc;
               if (quote_ff == dft_pkg::QUOTE_INSIDE) begin
                  quote_in = dft_pkg::QUOTE_CLOSED;
               end else if (quote_ff == dft_pkg::QUOTE_CLOSED) begin
                  // doubled quote: literal
                  quote_in       = dft_pkg::QUOTE_INSIDE;
                  res_valid      = 1'b1;
                  res.field_byte = b;
                  nonempty_in    = 1'b1;
               end else if (nonempty_ff) begin
                  res_valid      = 1'b1;
                  res.field_byte = b;
               end else begin
                  quote_in = dft_pkg::QUOTE_INSIDE;
               end
            end else if (quote_ff == dft_pkg::QUOTE_CLOSED) begin
               phase_in           = dft_pkg::PHASE_STOP;
               stop_status_in     = dft_pkg::STATUS_BAD_QUOTES;
               res_valid          = 1'b1;
               res.kind           = dft_pkg::KIND_ERROR;
               res.status         = dft_pkg::STATUS_BAD_QUOTES;
               res.bytes_consumed = dft_pkg::BYTES_OUT_WIDTH'(byte_count_ff);
            end else begin
               byte_count_in = byte_count_inc;
               if (!(is_blank && quote_ff == dft_pkg::QUOTE_OUTSIDE && !nonempty_ff)) begin
                  res_valid      = 1'b1;
                  res.field_byte = b;
                  nonempty_in    = 1'b1;
               end
            end
         end
      end

      if (cfg.skip_load) begin
         skip_rem_in = cfg.skip_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= dft_pkg::PHASE_SKIP;
         quote_ff       <= dft_pkg::QUOTE_OUTSIDE;
         stop_status_ff <= dft_pkg::STATUS_OK;
         nonempty_ff    <= 1'b0;
         column_ff      <= '0;
         row_ff         <= '0;
         byte_count_ff  <= '0;
         skip_rem_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         quote_ff       <= quote_in;
         stop_status_ff <= stop_status_in;
         nonempty_ff    <= nonempty_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         byte_count_ff  <= byte_count_in;
         skip_rem_ff    <= skip_rem_in;
      end
   end

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.kind == dft_pkg::KIND_ERROR) |=>
         (phase_ff == dft_pkg::PHASE_STOP && stop_status_ff == dft_pkg::STATUS_BAD_QUOTES))
      else $error("error result did not stop parsing");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dft_pkg::PHASE_DONE) |-> !res_valid)
      else $error("result produced after summary");

   a_skip_holds_quote: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dft_pkg::PHASE_SKIP) |->
         (quote_ff == dft_pkg::QUOTE_OUTSIDE && column_ff == '0 && row_ff == '0))
      else $error("parse state touched during line skipping");

endmodule

@@ rtl/delimited_field_tokenizer_core.sv @@
// channel  ports                              payload
// req      req_valid req_stall req_data       dft_pkg::req_payload_type
// rsp      rsp_valid rsp_stall rsp_data       dft_pkg::rsp_payload_type
// csr      csr_valid csr_ready csr_index      csr_wdata (register write)
//
// One item per cycle while req_stall is low: an item goes into the input register,
// is parsed once the output register is free or being drained, and its result, if
// any, lands in the output register, which drives rsp_valid.
// reset is synchronous: config returns to defaults, parser to line skipping.
// req_stall rises only while a held result is stalled and the input register is full.
module delimited_field_tokenizer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dft_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dft_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dft_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dft_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   dft_pkg::req_payload_type in_data_ff, in_data_in;
   logic                     out_valid_ff, out_valid_in;
   dft_pkg::rsp_payload_type out_data_ff, out_data_in;

   logic                     advance;
   logic                     fire;
   logic                     req_take;
   logic                     res_valid;
   dft_pkg::rsp_payload_type res;
   logic                     skip_open;
   dft_pkg::cfg_bus_type     cfg;

   dft_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .skip_open (skip_open),
      .cfg       (cfg)
   );

   dft_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (fire),
      .item      (in_data_ff),
      .res_valid (res_valid),
      .res       (res),
      .skip_open (skip_open)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_data_in  = in_data_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_data_in  = req_data;
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = fire && res_valid;
         if (fire && res_valid) begin
            out_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("input stalled without a blocked result");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.kind == dft_pkg::KIND_SUMMARY) |=> !rsp_valid)
      else $error("result after summary transfer");

   a_byte_only_content: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != dft_pkg::KIND_FIELD_BYTE) |-> (rsp_data.field_byte == 8'd0))
      else $error("field byte set on non-content result");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam logic [dft_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 8'hFF;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum int {
      END_CLEAN,
      END_SHORT,
      END_MID_ROW,
      END_QUOTE_JUNK,
      END_QUOTE_NL,
      END_BYTE_LIMIT,
      END_ROW_LIMIT
   } ending_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   dft_pkg::req_payload_type            req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   dft_pkg::rsp_payload_type            rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dft_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [dft_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // tokenizer state as predicted
   logic [7:0]                           cfg_delim;
   logic [dft_pkg::SKIP_WIDTH-1:0]       cfg_skip;
   logic [dft_pkg::LIMIT_ROW_WIDTH-1:0]  cfg_rows;
   logic [dft_pkg::LIMIT_BYTE_WIDTH-1:0] cfg_bytes;
   dft_pkg::phase_type                   scan_phase;
   dft_pkg::quote_type                   quoting;
   bit                                   field_open;
   dft_pkg::status_type                  halt_status;
   logic [dft_pkg::COLUMN_WIDTH-1:0]     cur_column;
   logic [dft_pkg::ROW_WIDTH-1:0]        cur_row;
   logic [dft_pkg::BYTE_COUNT_WIDTH-1:0] bytes_seen;
   logic [dft_pkg::SKIP_WIDTH-1:0]       lines_to_skip;

   dft_pkg::rsp_payload_type expected_tokens [$];
   int                       mismatches = 0;
   int                       cycles = 0;
   int unsigned              take_hold = 0;
   bit                       send_idle = 1'b1;
   bit                       take_idle = 1'b1;

   delimited_field_tokenizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] saturate_inc(logic [63:0] v, int w);
      logic [63:0] top;
      top = (64'd1 << w) - 64'd1;
      return (v < top) ? v + 64'd1 : v;
   endfunction

   function automatic logic [dft_pkg::BYTE_COUNT_WIDTH-1:0] next_bytes_seen();
      return dft_pkg::BYTE_COUNT_WIDTH'(saturate_inc(64'(bytes_seen),
                                                     dft_pkg::BYTE_COUNT_WIDTH));
   endfunction

   function automatic dft_pkg::rsp_payload_type token(dft_pkg::kind_type k, logic [7:0] fb,
                                                      dft_pkg::status_type st,
                                                      logic [47:0] n, logic [31:0] skipped);
      dft_pkg::rsp_payload_type r;
      r.kind           = k;
      r.field_byte     = fb;
      r.column_index   = cur_column;
      r.row_index      = cur_row;
      r.status         = st;
      r.bytes_consumed = n;
      r.rows_skipped   = skipped;
      return r;
   endfunction

   function automatic dft_pkg::rsp_payload_type content_token(logic [7:0] b);
      field_open = 1'b1;
      return token(dft_pkg::KIND_FIELD_BYTE, b, dft_pkg::STATUS_OK, '0, '0);
   endfunction

   function automatic dft_pkg::rsp_payload_type quote_error();
      scan_phase  = dft_pkg::PHASE_STOP;
      halt_status = dft_pkg::STATUS_BAD_QUOTES;
      return token(dft_pkg::KIND_ERROR, 8'h00, dft_pkg::STATUS_BAD_QUOTES, bytes_seen, '0);
   endfunction

   function automatic bit tokenize(dft_pkg::req_payload_type it,
                                   output dft_pkg::rsp_payload_type r);
      logic [7:0] b;
      dft_pkg::status_type st;
      b = it.data_byte;
      r = '0;
      if (scan_phase == dft_pkg::PHASE_DONE) return 1'b0;
      if (it.mode == dft_pkg::MODE_END) begin
         if (halt_status != dft_pkg::STATUS_OK) st = halt_status;
         else if (cur_column != 0) st = dft_pkg::STATUS_MID_ROW;
         else if (cfg_rows != 0 && cur_row < cfg_rows) st = dft_pkg::STATUS_SHORT;
         else st = dft_pkg::STATUS_OK;
         scan_phase = dft_pkg::PHASE_DONE;
         r = token(dft_pkg::KIND_SUMMARY, 8'h00, st, bytes_seen, cfg_skip - lines_to_skip);
         return 1'b1;
      end
      if (scan_phase == dft_pkg::PHASE_STOP) return 1'b0;
      if (cfg_bytes != 0 && bytes_seen >= cfg_bytes) begin
         scan_phase = dft_pkg::PHASE_STOP;
         return 1'b0;
      end
      if (scan_phase == dft_pkg::PHASE_SKIP) begin
         if (lines_to_skip != 0) begin
            bytes_seen = next_bytes_seen();
            if (b == dft_pkg::CH_NL) begin
               lines_to_skip--;
               if (lines_to_skip == 0) scan_phase = dft_pkg::PHASE_PARSE;
            end
            return 1'b0;
         end
         scan_phase = dft_pkg::PHASE_PARSE;
      end
      if (cfg_rows != 0 && cur_row >= cfg_rows) begin
         scan_phase = dft_pkg::PHASE_STOP;
         return 1'b0;
      end
      // delimiter outside quotes wins over every other byte class
      if (b == cfg_delim && quoting != dft_pkg::QUOTE_INSIDE) begin
         r = token(dft_pkg::KIND_FIELD_END, 8'h00, dft_pkg::STATUS_OK, '0, '0);
         bytes_seen = next_bytes_seen();
         quoting    = dft_pkg::QUOTE_OUTSIDE;
         field_open = 1'b0;
         cur_column = dft_pkg::COLUMN_WIDTH'(saturate_inc(64'(cur_column),
                                                          dft_pkg::COLUMN_WIDTH));
         return 1'b1;
      end
      if (b == cfg_delim) begin
         bytes_seen = next_bytes_seen();
         r = content_token(b);
         return 1'b1;
      end
      if (b == dft_pkg::CH_NL) begin
         if (quoting == dft_pkg::QUOTE_INSIDE) begin
            r = quote_error();
            return 1'b1;
         end
         r = token(dft_pkg::KIND_ROW_END, 8'h00, dft_pkg::STATUS_OK, '0, '0);
         bytes_seen = next_bytes_seen();
         quoting    = dft_pkg::QUOTE_OUTSIDE;
         field_open = 1'b0;
         cur_column = '0;
         cur_row    = dft_pkg::ROW_WIDTH'(saturate_inc(64'(cur_row), dft_pkg::ROW_WIDTH));
         return 1'b1;
      end
      if (b == dft_pkg::CH_QUOTE) begin
         bytes_seen = next_bytes_seen();
         if (quoting == dft_pkg::QUOTE_INSIDE) begin
            quoting = dft_pkg::QUOTE_CLOSED;
            return 1'b0;
         end
         if (quoting == dft_pkg::QUOTE_CLOSED) begin
            quoting = dft_pkg::QUOTE_INSIDE;
            r = content_token(b);
            return 1'b1;
         end
         if (field_open) begin
            r = content_token(b);
            return 1'b1;
         end
         quoting = dft_pkg::QUOTE_INSIDE;
         return 1'b0;
      end
      if (quoting == dft_pkg::QUOTE_CLOSED) begin
         r = quote_error();
         return 1'b1;
      end
      bytes_seen = next_bytes_seen();
      if ((b == dft_pkg::CH_SPACE || b == dft_pkg::CH_TAB) &&
          quoting == dft_pkg::QUOTE_OUTSIDE && !field_open)
         return 1'b0;
      r = content_token(b);
      return 1'b1;
   endfunction

   // true when this byte would end parsing with a quote error
   function automatic bit breaks_quoting(logic [7:0] b);
      if (scan_phase == dft_pkg::PHASE_SKIP && lines_to_skip != 0) return 1'b0;
      if (scan_phase == dft_pkg::PHASE_STOP || scan_phase == dft_pkg::PHASE_DONE) return 1'b0;
      if (b == cfg_delim) return 1'b0;
      if (quoting == dft_pkg::QUOTE_INSIDE) return b == dft_pkg::CH_NL;
      if (quoting == dft_pkg::QUOTE_CLOSED) return b != dft_pkg::CH_QUOTE && b != dft_pkg::CH_NL;
      return 1'b0;
   endfunction

   function automatic logic [7:0] next_text_byte();
      logic [7:0] b;
      do begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: b = 8'($urandom_range(0, 255));
            4, 5, 6:    b = cfg_delim;
            7:          b = dft_pkg::CH_NL;
            8, 9, 10:   b = dft_pkg::CH_QUOTE;
            11:         b = dft_pkg::CH_SPACE;
            12:         b = dft_pkg::CH_TAB;
            13:         b = CH_CR;
            default:    b = 8'h61 + 8'($urandom_range(0, 25));
         endcase
      end while (breaks_quoting(b));
      return b;
   endfunction

   task automatic send_input(dft_pkg::mode_type m, logic [7:0] b);
      dft_pkg::req_payload_type it;
      dft_pkg::rsp_payload_type r;
      int gap;
      it.mode      = m;
      it.data_byte = b;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      if (tokenize(it, r)) expected_tokens.push_back(r);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_input(dft_pkg::MODE_BYTE, s[i]);
   endtask

   task automatic write_csr(logic [dft_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [dft_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dft_pkg::CSR_DELIMITER:  cfg_delim = val[7:0];
         dft_pkg::CSR_SKIP_ROWS: begin
            if (scan_phase == dft_pkg::PHASE_SKIP && bytes_seen == 0) begin
               cfg_skip      = val[dft_pkg::SKIP_WIDTH-1:0];
               lines_to_skip = val[dft_pkg::SKIP_WIDTH-1:0];
            end
         end
         dft_pkg::CSR_ROW_LIMIT:  cfg_rows  = val[dft_pkg::LIMIT_ROW_WIDTH-1:0];
         dft_pkg::CSR_BYTE_LIMIT: cfg_bytes = val[dft_pkg::LIMIT_BYTE_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic compare(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      dft_pkg::rsp_payload_type want;
      if (reset) begin
         take_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t unexpected result: expected none actual kind %0d",
                        $time, rsp_data.kind);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               compare("kind", 64'(want.kind), 64'(rsp_data.kind));
               compare("field_byte", 64'(want.field_byte), 64'(rsp_data.field_byte));
               compare("column_index", 64'(want.column_index), 64'(rsp_data.column_index));
               compare("row_index", 64'(want.row_index), 64'(rsp_data.row_index));
               compare("status", 64'(want.status), 64'(rsp_data.status));
               compare("bytes_consumed", 64'(want.bytes_consumed),
                       64'(rsp_data.bytes_consumed));
               compare("rows_skipped", 64'(want.rows_skipped), 64'(rsp_data.rows_skipped));
            end
            take_hold = take_idle ? $urandom_range(0, 7) : 0;
         end else if (take_hold != 0) begin
            take_hold--;
         end
         rsp_stall <= (take_hold != 0);
      end
   end

   task automatic test_skip_rows();
      int lines;
      int n;
      lines = $urandom_range(1, 3);
      write_csr(dft_pkg::CSR_SKIP_ROWS, '1);
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      write_csr(dft_pkg::CSR_SKIP_ROWS, '0);
      write_csr(dft_pkg::CSR_SKIP_ROWS, {32'($urandom), 32'(lines)});
      csr_done();
      repeat (lines) begin
         n = $urandom_range(0, 8);
         send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_QUOTE);
         repeat (n) send_input(dft_pkg::MODE_BYTE,
                               $urandom_range(0, 255) == dft_pkg::CH_NL ? CH_CR : 8'h2C);
         repeat (n) send_input(dft_pkg::MODE_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
         send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
      end
   endtask

   task automatic test_quote_rules();
      send_text(" \ta,\"x,\"\"y\"\n");
      send_text("ab\"c,\"q\"\n");
      send_text(",\"\",");
      send_input(dft_pkg::MODE_BYTE, CH_CR);
      send_input(dft_pkg::MODE_BYTE, 8'h00);
      send_input(dft_pkg::MODE_BYTE, 8'hFF);
      send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
   endtask

   task automatic test_delimiters();
      logic [7:0] picks [7];
      logic [7:0] line [13];
      logic [7:0] d;
      picks = '{8'h00, 8'hFF, dft_pkg::CH_QUOTE, dft_pkg::CH_SPACE, dft_pkg::CH_TAB,
                dft_pkg::CH_NL, 8'h3B};
      settle();
      write_csr(dft_pkg::CSR_ROW_LIMIT, '1);
      write_csr(dft_pkg::CSR_BYTE_LIMIT, '1);
      write_csr(dft_pkg::CSR_SKIP_ROWS, {$urandom, $urandom});
      csr_done();
      foreach (picks[k]) begin
         d = picks[k];
         settle();
         write_csr(dft_pkg::CSR_DELIMITER, {$urandom, 24'($urandom), d});
         csr_done();
         send_idle = ($urandom_range(0, 1) != 0);
         take_idle = ($urandom_range(0, 1) != 0);
         line = '{dft_pkg::CH_QUOTE, d, dft_pkg::CH_QUOTE, d, 8'h78, d, dft_pkg::CH_SPACE, d,
                  dft_pkg::CH_TAB, 8'h79, dft_pkg::CH_QUOTE, d, dft_pkg::CH_NL};
         foreach (line[i])
            if (!breaks_quoting(line[i])) send_input(dft_pkg::MODE_BYTE, line[i]);
         repeat (6) send_input(dft_pkg::MODE_BYTE, next_text_byte());
         if (!breaks_quoting(dft_pkg::CH_NL)) send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
      end
   endtask

   task automatic test_random_rows();
      repeat (6) begin
         settle();
         write_csr(dft_pkg::CSR_DELIMITER, $urandom_range(0, 4) != 0
                                              ? 64'(dft_pkg::DELIMITER_RESET)
                                              : 64'($urandom_range(0, 255)));
         case ($urandom_range(0, 2))
            0: write_csr(dft_pkg::CSR_ROW_LIMIT, '0);
            1: write_csr(dft_pkg::CSR_ROW_LIMIT, '1);
            default: write_csr(dft_pkg::CSR_ROW_LIMIT, 64'(cur_row + 32'd1000));
         endcase
         case ($urandom_range(0, 2))
            0: write_csr(dft_pkg::CSR_BYTE_LIMIT, '0);
            1: write_csr(dft_pkg::CSR_BYTE_LIMIT, '1);
            default: write_csr(dft_pkg::CSR_BYTE_LIMIT, 64'(bytes_seen + 48'd100000));
         endcase
         if ($urandom_range(0, 3) == 0)
            write_csr(dft_pkg::CSR_SKIP_ROWS, 64'($urandom_range(0, 5)));
         csr_done();
         send_idle = $urandom_range(0, 2) != 0;
         take_idle = $urandom_range(0, 2) != 0;
         repeat (250) send_input(dft_pkg::MODE_BYTE, next_text_byte());
      end
   endtask

   task automatic test_stop_and_summary();
      ending_type how;
      how = ending_type'($urandom_range(END_CLEAN, END_ROW_LIMIT));
      settle();
      send_idle = ($urandom_range(0, 1) != 0);
      take_idle = ($urandom_range(0, 1) != 0);
      write_csr(dft_pkg::CSR_DELIMITER, 64'(dft_pkg::DELIMITER_RESET));
      if (how == END_SHORT) write_csr(dft_pkg::CSR_ROW_LIMIT, '1);
      else if (how == END_ROW_LIMIT) write_csr(dft_pkg::CSR_ROW_LIMIT, 64'(cur_row + 32'd2));
      else write_csr(dft_pkg::CSR_ROW_LIMIT, '0);
      if (how == END_BYTE_LIMIT)
         write_csr(dft_pkg::CSR_BYTE_LIMIT, 64'(bytes_seen + 48'($urandom_range(1, 20))));
      else write_csr(dft_pkg::CSR_BYTE_LIMIT, '0);
      csr_done();
      if (quoting == dft_pkg::QUOTE_INSIDE) send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_QUOTE);
      case (how)
         END_CLEAN, END_SHORT: send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
         END_MID_ROW:          send_text("a,b");
         END_QUOTE_JUNK: begin
            send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
            send_text("\"ab\"x");
         end
         END_QUOTE_NL: begin
            send_input(dft_pkg::MODE_BYTE, dft_pkg::CH_NL);
            send_text("\"a\n");
         end
         default: repeat (60) send_input(dft_pkg::MODE_BYTE, next_text_byte());
      endcase
      if (how >= END_QUOTE_JUNK)
         repeat (5) send_input(dft_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
      send_input(dft_pkg::MODE_END, 8'($urandom_range(0, 255)));
      repeat (4) send_input(dft_pkg::mode_type'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
   endtask

   initial begin
      cfg_delim     = dft_pkg::DELIMITER_RESET;
      cfg_skip      = '0;
      cfg_rows      = '0;
      cfg_bytes     = '0;
      scan_phase    = dft_pkg::PHASE_SKIP;
      quoting       = dft_pkg::QUOTE_OUTSIDE;
      field_open    = 1'b0;
      halt_status   = dft_pkg::STATUS_OK;
      cur_column    = '0;
      cur_row       = '0;
      bytes_seen    = '0;
      lines_to_skip = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_skip_rows();
      test_quote_rules();
      test_delimiters();
      test_random_rows();
      test_stop_and_summary();
      settle();
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ delimited_field_tokenizer_core.f @@
rtl/dft_pkg.sv
rtl/dft_csr_regs.sv
rtl/dft_parser.sv
rtl/delimited_field_tokenizer_core.sv
test/tb.sv
